// ===== src/pcds_pkg.sv =====
// ----------------------------------------------------------------------------
// pcds_pkg
// Shared types and constants for the per-channel delay statistics core.
// ----------------------------------------------------------------------------
package pcds_pkg;

    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DATA_W           = 32;
    localparam int REQ_W            = 2;
    localparam int CHAN_W           = 4;
    localparam int DIV_STEPS        = 32;
    localparam int DIV_CNT_W        = 5;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PRODUCED = 2'd0,
        REQ_CONSUMED = 2'd1,
        REQ_READ     = 2'd2,
        REQ_SPARE    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SUM,
        ST_DIV,
        ST_WR
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] made;
        logic [DATA_W-1:0] eaten;
        logic [DATA_W-1:0] min_delay;
        logic [DATA_W-1:0] mean;
        logic [DATA_W-1:0] max_delay;
    } entry_t;

endpackage

// ===== src/per_channel_delay_statistics_core.sv =====
// ----------------------------------------------------------------------------
// per_channel_delay_statistics_core
// Per-channel produced/consumed counts with min, max and running mean delay.
// ----------------------------------------------------------------------------
// One request is processed at a time. Produced, read and out-of-range
// requests pass the update state and then the write state; a consumed
// request also passes a sum state and the 32-step radix-2 divider that forms
// the new mean (one 32x32 multiply and one 64-bit add precede it). The input
// reopens in the cycle after the result is loaded, so requests do not overlap.
// Statistics live in one single-port table read as the input transfer is
// taken and written back when the result is loaded, except for out-of-range
// requests; a per-entry valid flag cleared by reset makes every entry read as
// zero until first written, so no clearing pass is needed and requests are
// taken right out of reset. The result register lets the next request start
// while a result still waits on m_ready.
// ----------------------------------------------------------------------------
module per_channel_delay_statistics_core #(
    parameter int NUM_CHANNELS = pcds_pkg::DEF_NUM_CHANNELS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pcds_pkg::REQ_W-1:0]  s_req_type,
    input  logic [pcds_pkg::CHAN_W-1:0] s_channel,
    input  logic [pcds_pkg::DATA_W-1:0] s_delay,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pcds_pkg::DATA_W-1:0] m_made_count,
    output logic [pcds_pkg::DATA_W-1:0] m_eaten_count,
    output logic [pcds_pkg::DATA_W-1:0] m_min_delay,
    output logic [pcds_pkg::DATA_W-1:0] m_mean_delay,
    output logic [pcds_pkg::DATA_W-1:0] m_max_delay
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW    = pcds_pkg::DATA_W;

    pcds_pkg::state_t state_reg, state_next;

    pcds_pkg::entry_t mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] vld_reg;

    pcds_pkg::entry_t rdata_reg;
    logic             rd_vld_reg;
    pcds_pkg::entry_t ent_reg;
    pcds_pkg::entry_t ent_next;
    pcds_pkg::entry_t cur_ent;
    pcds_pkg::entry_t wr_ent;
    pcds_pkg::entry_t out_reg;

    logic [pcds_pkg::REQ_W-1:0] req_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [DW-1:0]              delay_reg;
    logic                       oor_reg;
    logic                       cons_reg;

    logic [2*DW-1:0]                 prod_reg;
    logic [2*DW-1:0]                 sum;
    logic [DW-1:0]                   rem_reg, rem_next;
    logic [DW-1:0]                   quo_reg;
    logic [DW:0]                     rem_shift;
    logic                            quo_bit;
    logic [pcds_pkg::DIV_CNT_W-1:0]  cnt_reg;

    logic                   m_valid_reg;
    logic                   accept;
    logic                   out_free;
    logic                   mem_we;
    logic                   out_load;
    logic [8:0]             ch_ext;
    logic [IDX_W-1:0]       addr;
    logic                   oor;

    assign ch_ext = {5'd0, s_channel};
    assign addr   = ch_ext[IDX_W-1:0];
    assign oor    = (ch_ext >= 9'(NUM_CHANNELS));
    assign accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcds_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pcds_pkg::ST_UPD;
                end
            end
            pcds_pkg::ST_UPD: begin
                state_next = cons_reg && !oor_reg ? pcds_pkg::ST_SUM : pcds_pkg::ST_WR;
            end
            pcds_pkg::ST_SUM: begin
                state_next = pcds_pkg::ST_DIV;
            end
            pcds_pkg::ST_DIV: begin
                if (cnt_reg == pcds_pkg::DIV_CNT_W'(pcds_pkg::DIV_STEPS - 1)) begin
                    state_next = pcds_pkg::ST_WR;
                end
            end
            pcds_pkg::ST_WR: begin
                if (out_free) begin
                    state_next = pcds_pkg::ST_IDLE;
                end
            end
            default: state_next = pcds_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        mem_we   = 1'b0;
        case (state_reg)
            pcds_pkg::ST_IDLE: s_ready = 1'b1;
            pcds_pkg::ST_WR: begin
                out_load = out_free;
                mem_we   = out_free && !oor_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcds_pkg::ST_IDLE;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                vld_reg[idx_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // statistics table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= wr_ent;
        end
        if (accept) begin
            rdata_reg  <= mem[addr];
            rd_vld_reg <= vld_reg[addr];
        end
    end

    // entry update
    always_comb begin
        cur_ent  = rd_vld_reg ? rdata_reg : '0;
        ent_next = cur_ent;
        if (oor_reg) begin
            ent_next = '0;
        end else begin
            case (pcds_pkg::req_t'(req_reg))
                pcds_pkg::REQ_PRODUCED: begin
                    if (cur_ent.made != pcds_pkg::COUNT_MAX) begin
                        ent_next.made = cur_ent.made + 1'b1;
                    end
                end
                pcds_pkg::REQ_CONSUMED: begin
                    if (cur_ent.eaten != pcds_pkg::COUNT_MAX) begin
                        ent_next.eaten = cur_ent.eaten + 1'b1;
                    end
                    if (cur_ent.min_delay == '0 || cur_ent.min_delay > delay_reg) begin
                        ent_next.min_delay = delay_reg;
                    end
                    if (cur_ent.max_delay < delay_reg) begin
                        ent_next.max_delay = delay_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // divider step: remainder stays below n, quotient fits 32 bits
    always_comb begin
        sum       = prod_reg + {{DW{1'b0}}, delay_reg};
        rem_shift = {rem_reg, quo_reg[DW-1]};
        quo_bit   = (rem_shift >= {1'b0, ent_reg.eaten});
        rem_next  = quo_bit ? DW'(rem_shift - {1'b0, ent_reg.eaten}) : rem_shift[DW-1:0];
    end

    always_comb begin
        wr_ent = ent_reg;
        if (cons_reg && !oor_reg) begin
            wr_ent.mean = quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg   <= s_req_type;
            idx_reg   <= addr;
            delay_reg <= s_delay;
            oor_reg   <= oor;
            cons_reg  <= (pcds_pkg::req_t'(s_req_type) == pcds_pkg::REQ_CONSUMED);
        end
        case (state_reg)
            pcds_pkg::ST_UPD: begin
                ent_reg  <= ent_next;
                // n - 1 is the stored count, or one below it when saturated
                prod_reg <= (2*DW)'(cur_ent.mean)
                            * (2*DW)'((cur_ent.eaten == pcds_pkg::COUNT_MAX)
                                      ? pcds_pkg::COUNT_MAX - 1'b1 : cur_ent.eaten);
            end
            pcds_pkg::ST_SUM: begin
                rem_reg <= sum[2*DW-1:DW];
                quo_reg <= sum[DW-1:0];
                cnt_reg <= '0;
            end
            pcds_pkg::ST_DIV: begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DW-2:0], quo_bit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            out_reg <= wr_ent;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_made_count  = out_reg.made;
    assign m_eaten_count = out_reg.eaten;
    assign m_min_delay   = out_reg.min_delay;
    assign m_mean_delay  = out_reg.mean;
    assign m_max_delay   = out_reg.max_delay;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a result is pending");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcds_pkg::ST_DIV) |-> (rem_reg < ent_reg.eaten))
        else $error("divider remainder not below divisor");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcds_pkg::ST_DIV
         && cnt_reg == pcds_pkg::DIV_CNT_W'(pcds_pkg::DIV_STEPS - 1))
        |=> (state_reg == pcds_pkg::ST_WR))
        else $error("divider did not finish after its step count");

    a_mean_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcds_pkg::ST_WR && cons_reg && !oor_reg)
        |-> (quo_reg <= ent_reg.max_delay))
        else $error("mean above max delay");

endmodule
